// ===== rtl/core/cau_pkg.sv =====
// Shared types, constants and saturation helper for the complex arithmetic unit.
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;
  localparam int MAX_DW         = 32;
  localparam int MAX_FRAC       = 24;
  localparam int MAG_W          = 2 * MAX_DW + MAX_FRAC + 2;
  localparam int FIFO_DEPTH     = 4;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_CONJ = 4'd4,
    OP_LT   = 4'd5,
    OP_GT   = 4'd6,
    OP_EQ   = 4'd7,
    OP_NE   = 4'd8
  } op_t;

  typedef struct packed {
    logic is_div;
    logic dz;
    logic cmp;
    logic ovf;
  } flags_t;

  // Width of one queue entry: flags, two signs, den, two numerators, two results.
  function automatic int entry_w(input int dw);
    return $bits(flags_t) + 2 + 3 * (2 * dw) + 2 * dw;
  endfunction

  // Saturates a sign and magnitude to a dw-bit signed value; the top bit of the
  // return value is the overflow flag.
  function automatic logic [MAX_DW:0] sat_sm(input logic neg, input logic [MAG_W-1:0] mag,
                                             input int dw);
    logic [MAG_W-1:0] neg_lim;
    logic [MAG_W-1:0] pos_lim;
    logic [MAG_W-1:0] v;
    logic             o;
    neg_lim = {{(MAG_W-1){1'b0}}, 1'b1} << (dw - 1);
    pos_lim = neg_lim - {{(MAG_W-1){1'b0}}, 1'b1};
    o = 1'b0;
    v = mag;
    if (!neg) begin
      if (mag > pos_lim) begin
        o = 1'b1;
        v = pos_lim;
      end
    end else begin
      if (mag > neg_lim) begin
        o = 1'b1;
        v = neg_lim;
      end
      v = ~v + {{(MAG_W-1){1'b0}}, 1'b1};
    end
    return {o, v[MAX_DW-1:0]};
  endfunction

endpackage

// ===== rtl/core/cau_if.sv =====
// Operand and result channel interfaces of the complex arithmetic unit.
interface cau_op_if import cau_pkg::*; #(parameter int DW = DATA_WIDTH_DEF);
  logic                 valid;
  logic                 ready;
  logic [3:0]           operation;
  logic signed [DW-1:0] a_re;
  logic signed [DW-1:0] a_im;
  logic signed [DW-1:0] b_re;
  logic signed [DW-1:0] b_im;

  modport source (output valid, operation, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, operation, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_res_if import cau_pkg::*; #(parameter int DW = DATA_WIDTH_DEF);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] res_re;
  logic signed [DW-1:0] res_im;
  logic                 compare_true;
  logic                 overflow;
  logic                 div_by_zero;

  modport source (output valid, res_re, res_im, compare_true, overflow, div_by_zero,
                  input ready);
  modport sink (input valid, res_re, res_im, compare_true, overflow, div_by_zero,
                output ready);
endinterface

// ===== rtl/core/complex_arith_unit.sv =====
// Top level of the complex arithmetic unit: front end, queue and divider back end.
//
// Operands arrive on in_ch (valid/ready): an operation code and two complex
// values a and b in signed fixed point. Results leave on out_ch (valid/ready),
// one per item, in the order the items were taken.
// Throughput is one item per clock cycle for every operation, divides included,
// while the receiver takes each result. The divider pipeline resolves one
// quotient bit per stage for both result parts at once.
// The front end registers the operands and forms all eight products, then
// classifies the item and writes it into a four-entry queue.
// Non-divide items travel the same pipeline unchanged to keep their order.
// When the receiver stalls, the back end holds; the queue then fills and the
// front end drops in_ch.ready, so no item is lost.
// A synchronous reset clears all valid state; the block accepts items as soon
// as reset is released.
module complex_arith_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cau_op_if.sink    in_ch,
  cau_res_if.source out_ch
);

  localparam int EW = entry_w(DATA_WIDTH);

  logic          f_valid, f_ready;
  logic [EW-1:0] f_data;
  logic          b_valid, b_ready;
  logic [EW-1:0] b_data;

  cau_front #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  cau_fifo #(.W(EW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  cau_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data),
    .out_ch    (out_ch)
  );

`ifndef ASSERT_OFF
  // A front-end item refused by the queue must still be offered next cycle.
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !f_ready) |=> f_valid)
    else $error("front end dropped an item while the queue was full");

  // Divide by zero gives a zero result with no other flag.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.div_by_zero) |->
      (out_ch.res_re == '0 && out_ch.res_im == '0 && !out_ch.overflow &&
       !out_ch.compare_true))
    else $error("divide by zero result is not clean");

  // A true compare never carries result data or overflow.
  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.compare_true) |->
      (out_ch.res_re == '0 && out_ch.res_im == '0 && !out_ch.overflow))
    else $error("compare result carries data");
`endif

endmodule

// ===== rtl/core/cau_front.sv =====
// Front end: registers operands, forms all products and classifies each item.
module cau_front import cau_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  cau_op_if.sink                in_ch,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [entry_w(DW)-1:0] push_data
);

  localparam int PW  = 2 * DW;
  localparam int SW2 = PW + 1;
  localparam int MW  = 2 * DW;
  localparam logic [SW2:0] HALF = ((SW2 + 1)'(1) << FB) >> 1;

  logic en;
  logic v1, v2;
  op_t  op1, op2;
  logic signed [DW-1:0] ar, ai, br, bi;
  logic signed [DW-1:0] ar2, ai2, br2, bi2;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, s_ar, s_ai, s_br, s_bi;

  assign en = !v2 || push_ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= op_t'(in_ch.operation);
      ar   <= in_ch.a_re;
      ai   <= in_ch.a_im;
      br   <= in_ch.b_re;
      bi   <= in_ch.b_im;
      op2  <= op1;
      ar2  <= ar;
      ai2  <= ai;
      br2  <= br;
      bi2  <= bi;
      p_rr <= ar * br;
      p_ii <= ai * bi;
      p_ri <= ar * bi;
      p_ir <= ai * br;
      s_ar <= ar * ar;
      s_ai <= ai * ai;
      s_br <= br * br;
      s_bi <= bi * bi;
    end
  end

  function automatic logic [SW2-1:0] abs_w(input logic signed [SW2-1:0] x);
    return x[SW2-1] ? SW2'(-x) : SW2'(x);
  endfunction

  function automatic logic [DW:0] abs_n(input logic signed [DW:0] x);
    return x[DW] ? (DW + 1)'(-x) : (DW + 1)'(x);
  endfunction

  logic signed [SW2-1:0] e_rr, e_ii, e_ri, e_ir, e_sar, e_sai, e_sbr, e_sbi;
  logic signed [SW2-1:0] mul_re, mul_im, div_re, div_im, den_s, ma_s, mb_s;
  logic [SW2-1:0]        mag_mre, mag_mim, mag_dre, mag_dim;
  logic [SW2:0]          rnd_re, rnd_im;
  logic signed [DW:0]    add_re, add_im, sub_re, sub_im, conj_im;
  logic [MAX_DW:0]       st_add_re, st_add_im, st_sub_re, st_sub_im;
  logic [MAX_DW:0]       st_mul_re, st_mul_im, st_conj;

  assign e_rr  = {p_rr[PW-1], p_rr};
  assign e_ii  = {p_ii[PW-1], p_ii};
  assign e_ri  = {p_ri[PW-1], p_ri};
  assign e_ir  = {p_ir[PW-1], p_ir};
  assign e_sar = {s_ar[PW-1], s_ar};
  assign e_sai = {s_ai[PW-1], s_ai};
  assign e_sbr = {s_br[PW-1], s_br};
  assign e_sbi = {s_bi[PW-1], s_bi};

  assign mul_re = e_rr - e_ii;
  assign mul_im = e_ri + e_ir;
  assign div_re = e_rr + e_ii;
  assign div_im = e_ir - e_ri;
  assign den_s  = e_sbr + e_sbi;
  assign ma_s   = e_sar + e_sai;
  assign mb_s   = den_s;

  assign mag_mre = abs_w(mul_re);
  assign mag_mim = abs_w(mul_im);
  assign mag_dre = abs_w(div_re);
  assign mag_dim = abs_w(div_im);

  // Round to nearest with ties away from zero on the magnitude.
  assign rnd_re = ({1'b0, mag_mre} + HALF) >> FB;
  assign rnd_im = ({1'b0, mag_mim} + HALF) >> FB;

  assign add_re  = {ar2[DW-1], ar2} + {br2[DW-1], br2};
  assign add_im  = {ai2[DW-1], ai2} + {bi2[DW-1], bi2};
  assign sub_re  = {ar2[DW-1], ar2} - {br2[DW-1], br2};
  assign sub_im  = {ai2[DW-1], ai2} - {bi2[DW-1], bi2};
  assign conj_im = -{ai2[DW-1], ai2};

  assign st_add_re = sat_sm(add_re[DW], {{(MAG_W-DW-1){1'b0}}, abs_n(add_re)}, DW);
  assign st_add_im = sat_sm(add_im[DW], {{(MAG_W-DW-1){1'b0}}, abs_n(add_im)}, DW);
  assign st_sub_re = sat_sm(sub_re[DW], {{(MAG_W-DW-1){1'b0}}, abs_n(sub_re)}, DW);
  assign st_sub_im = sat_sm(sub_im[DW], {{(MAG_W-DW-1){1'b0}}, abs_n(sub_im)}, DW);
  assign st_conj   = sat_sm(conj_im[DW], {{(MAG_W-DW-1){1'b0}}, abs_n(conj_im)}, DW);
  assign st_mul_re = sat_sm(mul_re[SW2-1], {{(MAG_W-SW2-1){1'b0}}, rnd_re}, DW);
  assign st_mul_im = sat_sm(mul_im[SW2-1], {{(MAG_W-SW2-1){1'b0}}, rnd_im}, DW);

  flags_t           fl;
  logic [DW-1:0]    r_re, r_im;
  logic [MW-1:0]    den, ma, mb;

  assign den = den_s[MW-1:0];
  assign ma  = ma_s[MW-1:0];
  assign mb  = mb_s[MW-1:0];

  always_comb begin
    fl   = '0;
    r_re = '0;
    r_im = '0;
    case (op2)
      OP_ADD: begin
        r_re   = st_add_re[DW-1:0];
        r_im   = st_add_im[DW-1:0];
        fl.ovf = st_add_re[MAX_DW] | st_add_im[MAX_DW];
      end
      OP_SUB: begin
        r_re   = st_sub_re[DW-1:0];
        r_im   = st_sub_im[DW-1:0];
        fl.ovf = st_sub_re[MAX_DW] | st_sub_im[MAX_DW];
      end
      OP_MUL: begin
        r_re   = st_mul_re[DW-1:0];
        r_im   = st_mul_im[DW-1:0];
        fl.ovf = st_mul_re[MAX_DW] | st_mul_im[MAX_DW];
      end
      OP_DIV: begin
        if (den == '0) fl.dz = 1'b1;
        else fl.is_div = 1'b1;
      end
      OP_CONJ: begin
        r_re   = ar2;
        r_im   = st_conj[DW-1:0];
        fl.ovf = st_conj[MAX_DW];
      end
      OP_LT:   fl.cmp = ma < mb;
      OP_GT:   fl.cmp = ma > mb;
      OP_EQ:   fl.cmp = (ar2 == br2) && (ai2 == bi2);
      OP_NE:   fl.cmp = !((ar2 == br2) && (ai2 == bi2));
      default: fl = '0;
    endcase
  end

  assign push_valid = v2;
  assign push_data  = {fl, div_re[SW2-1], div_im[SW2-1], den, mag_dre[MW-1:0],
                       mag_dim[MW-1:0], r_re, r_im};

endmodule

// ===== rtl/core/cau_fifo.sv =====
// Small register queue between the front end and the divider back end.
module cau_fifo import cau_pkg::*; #(
  parameter int W     = entry_w(DATA_WIDTH_DEF),
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [0:DEPTH-1];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (do_pop) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_data;
  end

endmodule

// ===== rtl/core/cau_back.sv =====
// Back end: pipelined restoring divider, final rounding and the result register.
module cau_back import cau_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  logic [entry_w(DW)-1:0] pop_data,
  cau_res_if.source              out_ch
);

  localparam int MW     = 2 * DW;
  localparam int NW     = MW + FB + 1;
  localparam int O_RIM  = 0;
  localparam int O_RRE  = DW;
  localparam int O_NIM  = 2 * DW;
  localparam int O_NRE  = O_NIM + MW;
  localparam int O_DEN  = O_NRE + MW;
  localparam int O_NGI  = O_DEN + MW;
  localparam int O_NGR  = O_NGI + 1;
  localparam int O_FL   = O_NGR + 1;

  logic en;
  logic o_v;

  logic [NW:0]   v;
  flags_t        fl   [0:NW];
  logic [DW-1:0] rr   [0:NW];
  logic [DW-1:0] ri   [0:NW];
  logic          ngr  [0:NW];
  logic          ngi  [0:NW];
  logic [MW-1:0] dn   [0:NW];
  logic [MW-1:0] rm_r [0:NW];
  logic [MW-1:0] rm_i [0:NW];
  logic [NW-1:0] nq_r [0:NW];
  logic [NW-1:0] nq_i [0:NW];

  assign en        = !o_v || out_ch.ready;
  assign pop_ready = en;

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (en) v[0] <= pop_valid;
  end

  // The numerator enters pre-shifted by one more fractional bit for rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      fl[0]   <= pop_data[O_FL +: $bits(flags_t)];
      rr[0]   <= pop_data[O_RRE +: DW];
      ri[0]   <= pop_data[O_RIM +: DW];
      ngr[0]  <= pop_data[O_NGR];
      ngi[0]  <= pop_data[O_NGI];
      dn[0]   <= pop_data[O_DEN +: MW];
      rm_r[0] <= '0;
      rm_i[0] <= '0;
      nq_r[0] <= {pop_data[O_NRE +: MW], {(FB + 1){1'b0}}};
      nq_i[0] <= {pop_data[O_NIM +: MW], {(FB + 1){1'b0}}};
    end
  end

  for (genvar s = 0; s < NW; s++) begin : g_div
    logic [MW:0] tr_r, tr_i, df_r, df_i;
    logic        ge_r, ge_i;

    assign tr_r = {rm_r[s], nq_r[s][NW-1]};
    assign tr_i = {rm_i[s], nq_i[s][NW-1]};
    assign df_r = tr_r - {1'b0, dn[s]};
    assign df_i = tr_i - {1'b0, dn[s]};
    assign ge_r = tr_r >= {1'b0, dn[s]};
    assign ge_i = tr_i >= {1'b0, dn[s]};

    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (en) v[s+1] <= v[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl[s+1]   <= fl[s];
        rr[s+1]   <= rr[s];
        ri[s+1]   <= ri[s];
        ngr[s+1]  <= ngr[s];
        ngi[s+1]  <= ngi[s];
        dn[s+1]   <= dn[s];
        rm_r[s+1] <= ge_r ? df_r[MW-1:0] : tr_r[MW-1:0];
        rm_i[s+1] <= ge_i ? df_i[MW-1:0] : tr_i[MW-1:0];
        nq_r[s+1] <= {nq_r[s][NW-2:0], ge_r};
        nq_i[s+1] <= {nq_i[s][NW-2:0], ge_i};
      end
    end
  end

  logic [NW:0]     inc_r, inc_i;
  logic [MAX_DW:0] st_r, st_i;

  assign inc_r = {1'b0, nq_r[NW]} + (NW + 1)'(1);
  assign inc_i = {1'b0, nq_i[NW]} + (NW + 1)'(1);
  assign st_r  = sat_sm(ngr[NW], {{(MAG_W-NW){1'b0}}, inc_r[NW:1]}, DW);
  assign st_i  = sat_sm(ngi[NW], {{(MAG_W-NW){1'b0}}, inc_i[NW:1]}, DW);

  logic [DW-1:0] o_re, o_im;
  logic          o_cmp, o_ovf, o_dz;

  always_ff @(posedge clk) begin
    if (rst) o_v <= 1'b0;
    else if (en) o_v <= v[NW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_cmp <= fl[NW].cmp;
      o_dz  <= fl[NW].dz;
      if (fl[NW].is_div) begin
        o_re  <= st_r[DW-1:0];
        o_im  <= st_i[DW-1:0];
        o_ovf <= st_r[MAX_DW] | st_i[MAX_DW];
      end else begin
        o_re  <= rr[NW];
        o_im  <= ri[NW];
        o_ovf <= fl[NW].ovf;
      end
    end
  end

  assign out_ch.valid        = o_v;
  assign out_ch.res_re       = o_re;
  assign out_ch.res_im       = o_im;
  assign out_ch.compare_true = o_cmp;
  assign out_ch.overflow     = o_ovf;
  assign out_ch.div_by_zero  = o_dz;

endmodule
